>>> rtl/core/rtc_pkg.sv
`timescale 1ns / 1ps
package rtc_pkg;

    localparam int CW      = 32;
    localparam int EW      = CW + 1;
    localparam int PW      = 2 * EW;
    localparam int QW      = 2 * EW + 1;
    localparam int ACC_W   = 104;
    localparam int MA_W    = QW;
    localparam int MB_W    = EW;
    localparam int MP_W    = MA_W + MB_W;
    localparam int DIV_W   = ACC_W + 32;
    localparam int QT_W    = 32;
    localparam int TW      = 31;
    localparam int BW      = 17;
    localparam int HW      = 64;
    localparam int HS_W    = HW + 1;
    localparam int STEP_W  = 5;
    localparam int LAST_GEOM_STEP = 23;
    localparam int HIT_STEP       = 24;
    localparam int LAST_STEP      = 26;

    typedef logic signed [CW-1:0] crd_t;
    typedef logic signed [EW-1:0] ev_t;

    typedef struct packed {
        logic          restart;
        logic signed [CW-1:0] v0_x;
        logic signed [CW-1:0] v0_y;
        logic signed [CW-1:0] v0_z;
        logic signed [CW-1:0] v1_x;
        logic signed [CW-1:0] v1_y;
        logic signed [CW-1:0] v1_z;
        logic signed [CW-1:0] v2_x;
        logic signed [CW-1:0] v2_y;
        logic signed [CW-1:0] v2_z;
    } tri_in_t;

    typedef struct packed {
        logic          nearer_hit;
        logic [TW-1:0] hit_t;
        logic [BW-1:0] bary_u;
        logic [BW-1:0] bary_v;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
        logic [TW-1:0] closest_so_far;
    } hit_out_t;

    typedef struct packed {
        logic       restart;
        ev_t [2:0]  e1;
        ev_t [2:0]  e2;
        ev_t [2:0]  s;
    } tri_job_t;

    typedef enum logic [2:0] {
        R_ORIGIN_X, R_ORIGIN_Y, R_ORIGIN_Z, R_DIR_X, R_DIR_Y, R_DIR_Z, R_FAR_LIMIT
    } reg_idx_t;

    typedef enum logic [2:0] {A_E2, A_P, A_S, A_Q, A_DIR} asrc_t;
    typedef enum logic [2:0] {B_D, B_E1, B_S, B_E2, B_TQ} bsrc_t;
    typedef enum logic [2:0] {D_P, D_DET, D_NU, D_Q, D_NV, D_NT, D_H} dst_t;

    typedef struct packed {
        asrc_t      a_src;
        logic [1:0] a_idx;
        bsrc_t      b_src;
        logic [1:0] b_idx;
        logic       sub;
        logic       first;
        logic       last;
        dst_t       dst;
        logic [1:0] dst_idx;
    } uop_t;

    typedef struct packed {
        logic                   start;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [MP_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        logic [4:0]       top;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [QT_W-1:0] quo;
    } div_rsp_t;

    function automatic uop_t mk(input asrc_t as, input logic [1:0] ai, input bsrc_t bs,
                                input logic [1:0] bi, input logic sb, input logic f,
                                input logic l, input dst_t d, input logic [1:0] di);
        uop_t r;
        r.a_src = as; r.a_idx = ai; r.b_src = bs; r.b_idx = bi;
        r.sub = sb; r.first = f; r.last = l; r.dst = d; r.dst_idx = di;
        return r;
    endfunction

    // p = d x e2, det = e1.p, nu = s.p, q = s x e1, nv = d.q, nt = e2.q, h = dir*t
    function automatic uop_t uop(input logic [STEP_W-1:0] step);
        uop_t r;
        case (step)
            5'd0:  r = mk(A_E2, 2'd2, B_D,  2'd1, 1'b0, 1'b1, 1'b0, D_P,   2'd0);
            5'd1:  r = mk(A_E2, 2'd1, B_D,  2'd2, 1'b1, 1'b0, 1'b1, D_P,   2'd0);
            5'd2:  r = mk(A_E2, 2'd0, B_D,  2'd2, 1'b0, 1'b1, 1'b0, D_P,   2'd1);
            5'd3:  r = mk(A_E2, 2'd2, B_D,  2'd0, 1'b1, 1'b0, 1'b1, D_P,   2'd1);
            5'd4:  r = mk(A_E2, 2'd1, B_D,  2'd0, 1'b0, 1'b1, 1'b0, D_P,   2'd2);
            5'd5:  r = mk(A_E2, 2'd0, B_D,  2'd1, 1'b1, 1'b0, 1'b1, D_P,   2'd2);
            5'd6:  r = mk(A_P,  2'd0, B_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_DET, 2'd0);
            5'd7:  r = mk(A_P,  2'd1, B_E1, 2'd1, 1'b0, 1'b0, 1'b0, D_DET, 2'd0);
            5'd8:  r = mk(A_P,  2'd2, B_E1, 2'd2, 1'b0, 1'b0, 1'b1, D_DET, 2'd0);
            5'd9:  r = mk(A_P,  2'd0, B_S,  2'd0, 1'b0, 1'b1, 1'b0, D_NU,  2'd0);
            5'd10: r = mk(A_P,  2'd1, B_S,  2'd1, 1'b0, 1'b0, 1'b0, D_NU,  2'd0);
            5'd11: r = mk(A_P,  2'd2, B_S,  2'd2, 1'b0, 1'b0, 1'b1, D_NU,  2'd0);
            5'd12: r = mk(A_S,  2'd1, B_E1, 2'd2, 1'b0, 1'b1, 1'b0, D_Q,   2'd0);
            5'd13: r = mk(A_S,  2'd2, B_E1, 2'd1, 1'b1, 1'b0, 1'b1, D_Q,   2'd0);
            5'd14: r = mk(A_S,  2'd2, B_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_Q,   2'd1);
            5'd15: r = mk(A_S,  2'd0, B_E1, 2'd2, 1'b1, 1'b0, 1'b1, D_Q,   2'd1);
            5'd16: r = mk(A_S,  2'd0, B_E1, 2'd1, 1'b0, 1'b1, 1'b0, D_Q,   2'd2);
            5'd17: r = mk(A_S,  2'd1, B_E1, 2'd0, 1'b1, 1'b0, 1'b1, D_Q,   2'd2);
            5'd18: r = mk(A_Q,  2'd0, B_D,  2'd0, 1'b0, 1'b1, 1'b0, D_NV,  2'd0);
            5'd19: r = mk(A_Q,  2'd1, B_D,  2'd1, 1'b0, 1'b0, 1'b0, D_NV,  2'd0);
            5'd20: r = mk(A_Q,  2'd2, B_D,  2'd2, 1'b0, 1'b0, 1'b1, D_NV,  2'd0);
            5'd21: r = mk(A_Q,  2'd0, B_E2, 2'd0, 1'b0, 1'b1, 1'b0, D_NT,  2'd0);
            5'd22: r = mk(A_Q,  2'd1, B_E2, 2'd1, 1'b0, 1'b0, 1'b0, D_NT,  2'd0);
            5'd23: r = mk(A_Q,  2'd2, B_E2, 2'd2, 1'b0, 1'b0, 1'b1, D_NT,  2'd0);
            5'd24: r = mk(A_DIR, 2'd0, B_TQ, 2'd0, 1'b0, 1'b1, 1'b1, D_H,  2'd0);
            5'd25: r = mk(A_DIR, 2'd1, B_TQ, 2'd0, 1'b0, 1'b1, 1'b1, D_H,  2'd1);
            5'd26: r = mk(A_DIR, 2'd2, B_TQ, 2'd0, 1'b0, 1'b1, 1'b1, D_H,  2'd2);
            default: r = mk(A_E2, 2'd0, B_D, 2'd0, 1'b0, 1'b1, 1'b1, D_H, 2'd0);
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/ray_triangle_closest_hit.sv
`timescale 1ns / 1ps
// Nearest-hit search of one ray against a stream of triangles.
// Config: APB-style port, registers at 4*i: origin x/y/z, dir x/y/z (signed,
// FRAC_BITS fraction bits) and far_limit. Write only while the block is idle.
// Input beat (s_): one triangle plus a restart flag; restart reloads the kept
// nearest distance from far_limit before the test.
// Result beat (m_): one per triangle: nearer_hit, t, u, v, hit position and
// the kept nearest distance after this triangle.
// The front computes edges and queues up to two triangles; the back runs the
// test on one shared shift-add multiplier (24 products, 27 on a nearer hit)
// and one restoring divider (one quotient bit a cycle).
// The back works on one triangle at a time and starts the next one only once
// the result of the last has gone into the output register.
// Reset: origin 0, dir (0, 0, 1.0), far_limit and kept distance 2^31-1,
// queue and result register empty.
// A stalled result waits in the output register; the back finishes the next
// triangle, then holds, and the front takes beats until its queue is full.
module ray_triangle_closest_hit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  rtc_pkg::tri_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rtc_pkg::hit_out_t m_data
);
    import rtc_pkg::*;

    crd_t        origin_reg [3];
    crd_t        dir_reg [3];
    logic [30:0] far_limit_reg;
    logic        job_valid, job_pop;
    tri_job_t    job;
    reg_idx_t    ridx;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= crd_t'(32'sd1 <<< FRAC_BITS);
            far_limit_reg <= '1;
        end else if (psel && penable && pwrite && pready) begin
            case (ridx)
                R_ORIGIN_X:  origin_reg[0] <= pwdata;
                R_ORIGIN_Y:  origin_reg[1] <= pwdata;
                R_ORIGIN_Z:  origin_reg[2] <= pwdata;
                R_DIR_X:     dir_reg[0]    <= pwdata;
                R_DIR_Y:     dir_reg[1]    <= pwdata;
                R_DIR_Z:     dir_reg[2]    <= pwdata;
                R_FAR_LIMIT: far_limit_reg <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (ridx)
            R_ORIGIN_X:  prdata = origin_reg[0];
            R_ORIGIN_Y:  prdata = origin_reg[1];
            R_ORIGIN_Z:  prdata = origin_reg[2];
            R_DIR_X:     prdata = dir_reg[0];
            R_DIR_Y:     prdata = dir_reg[1];
            R_DIR_Z:     prdata = dir_reg[2];
            R_FAR_LIMIT: prdata = {1'b0, far_limit_reg};
            default:     prdata = '0;
        endcase
    end

    rtc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .origin    (origin_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    rtc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .origin    (origin_reg),
        .dir       (dir_reg),
        .far_limit (far_limit_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> rtl/core/rtc_front.sv
`timescale 1ns / 1ps
module rtc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtc_pkg::crd_t     origin [3],
    input  logic              s_valid,
    output logic              s_ready,
    input  rtc_pkg::tri_in_t  s_data,
    output logic              job_valid,
    output rtc_pkg::tri_job_t job,
    input  logic              job_pop
);
    import rtc_pkg::*;

    tri_job_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    tri_job_t   entry;
    logic       push;

    // edges and origin offset, taken relative to vertex 0
    always_comb begin
        entry.restart = s_data.restart;
        entry.e1[0] = EW'(s_data.v1_x) - EW'(s_data.v0_x);
        entry.e1[1] = EW'(s_data.v1_y) - EW'(s_data.v0_y);
        entry.e1[2] = EW'(s_data.v1_z) - EW'(s_data.v0_z);
        entry.e2[0] = EW'(s_data.v2_x) - EW'(s_data.v0_x);
        entry.e2[1] = EW'(s_data.v2_y) - EW'(s_data.v0_y);
        entry.e2[2] = EW'(s_data.v2_z) - EW'(s_data.v0_z);
        entry.s[0]  = EW'(origin[0]) - EW'(s_data.v0_x);
        entry.s[1]  = EW'(origin[1]) - EW'(s_data.v0_y);
        entry.s[2]  = EW'(origin[2]) - EW'(s_data.v0_z);
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign job_valid = (count_reg != 2'd0);
    assign job       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (job_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, job_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/core/rtc_mul.sv
`timescale 1ns / 1ps
module rtc_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtc_pkg::mul_req_t req,
    output rtc_pkg::mul_rsp_t rsp
);
    import rtc_pkg::*;

    // radix-2 shift-add; top multiplier bit carries negative weight
    logic signed [MP_W-1:0] acc_reg, mcand_reg;
    logic [MB_W-1:0]        mplier_reg;
    logic [5:0]             cnt_reg;
    logic                   busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg    <= '0;
            mcand_reg  <= MP_W'(req.a);
            mplier_reg <= req.b;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                if (cnt_reg == 6'(MB_W - 1)) begin
                    acc_reg <= acc_reg - mcand_reg;
                end else begin
                    acc_reg <= acc_reg + mcand_reg;
                end
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(MB_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

>>> rtl/core/rtc_div.sv
`timescale 1ns / 1ps
module rtc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtc_pkg::div_req_t req,
    output rtc_pkg::div_rsp_t rsp
);
    import rtc_pkg::*;

    // restoring division, one quotient bit a cycle from bit 'top' down
    logic [DIV_W-1:0] rem_reg, dsh_reg;
    logic [QT_W-1:0]  quo_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.num;
            dsh_reg <= req.den << req.top;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg          <= rem_reg - dsh_reg;
                quo_reg[cnt_reg] <= 1'b1;
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.top;
            end else if (busy_reg) begin
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> rtl/core/rtc_back.sv
`timescale 1ns / 1ps
module rtc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtc_pkg::crd_t     origin [3],
    input  rtc_pkg::crd_t     dir [3],
    input  logic [30:0]       far_limit,
    input  logic              job_valid,
    input  rtc_pkg::tri_job_t job,
    output logic              job_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output rtc_pkg::hit_out_t m_data
);
    import rtc_pkg::*;

    // smallest accepted |det|: 10000*|det| >= 2^(3F)
    localparam logic [79:0] DET_MIN_W =
        ((80'd1 << (3 * FRAC_BITS)) - 80'd1) / 80'd10000 + 80'd1;
    localparam logic [ACC_W-1:0] DET_MIN = DET_MIN_W[ACC_W-1:0];

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_GO    = 10'b0000000010,
        S_WAIT  = 10'b0000000100,
        S_NEG   = 10'b0000001000,
        S_EVAL  = 10'b0000010000,
        S_DIVT  = 10'b0000100000,
        S_CHECK = 10'b0001000000,
        S_DIVU  = 10'b0010000000,
        S_DIVV  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [STEP_W-1:0]       step_reg;
    logic                    go_reg, hit_reg, m_valid_reg;
    logic [TW-1:0]           closest_reg, tq_reg;
    logic [BW-1:0]           u_reg, v_reg;
    logic signed [ACC_W-1:0] acc_reg, det_reg, nu_reg, nv_reg, nt_reg;
    logic signed [PW-1:0]    p_reg [3];
    logic signed [QW-1:0]    q_reg [3];
    logic signed [HW-1:0]    h_reg [3];
    hit_out_t                out_reg, out_next;

    uop_t                    op;
    logic signed [MA_W-1:0]  a_val;
    logic signed [MB_W-1:0]  b_val;
    logic signed [ACC_W-1:0] term, acc_sum, uv_sum;
    logic                    in_range, out_free;
    mul_req_t                mreq;
    mul_rsp_t                mrsp;
    div_req_t                dreq;
    div_rsp_t                drsp;

    function automatic crd_t sat_pos(input crd_t org, input logic signed [HW-1:0] prod);
        logic signed [HS_W-1:0] sum;
        sum = HS_W'(org) + HS_W'(prod >>> FRAC_BITS);
        if (sum[HS_W-1:CW-1] == '0 || sum[HS_W-1:CW-1] == '1) begin
            sat_pos = sum[CW-1:0];
        end else if (sum[HS_W-1]) begin
            sat_pos = {1'b1, {(CW - 1){1'b0}}};
        end else begin
            sat_pos = {1'b0, {(CW - 1){1'b1}}};
        end
    endfunction

    assign op = uop(step_reg);

    always_comb begin
        case (op.a_src)
            A_E2:    a_val = MA_W'($signed(job.e2[op.a_idx]));
            A_P:     a_val = MA_W'(p_reg[op.a_idx]);
            A_S:     a_val = MA_W'($signed(job.s[op.a_idx]));
            A_Q:     a_val = q_reg[op.a_idx];
            A_DIR:   a_val = MA_W'(dir[op.a_idx]);
            default: a_val = '0;
        endcase
        case (op.b_src)
            B_D:     b_val = MB_W'(dir[op.b_idx]);
            B_E1:    b_val = $signed(job.e1[op.b_idx]);
            B_S:     b_val = $signed(job.s[op.b_idx]);
            B_E2:    b_val = $signed(job.e2[op.b_idx]);
            B_TQ:    b_val = $signed({2'b00, tq_reg});
            default: b_val = '0;
        endcase
    end

    assign mreq.start = (state_reg == S_GO);
    assign mreq.a     = a_val;
    assign mreq.b     = b_val;

    always_comb begin
        term    = op.sub ? -ACC_W'(mrsp.prod) : ACC_W'(mrsp.prod);
        acc_sum = op.first ? term : acc_reg + term;
    end

    always_comb begin
        dreq.start = go_reg;
        dreq.den   = {{(DIV_W - ACC_W){1'b0}}, det_reg};
        case (state_reg)
            S_DIVT: begin
                dreq.num = {{(DIV_W - ACC_W){1'b0}}, nt_reg} << FRAC_BITS;
                dreq.top = 5'd31;
            end
            S_DIVU: begin
                dreq.num = {{(DIV_W - ACC_W){1'b0}}, nu_reg} << FRAC_BITS;
                dreq.top = 5'(FRAC_BITS);
            end
            default: begin
                dreq.num = {{(DIV_W - ACC_W){1'b0}}, nv_reg} << FRAC_BITS;
                dreq.top = 5'(FRAC_BITS);
            end
        endcase
    end

    rtc_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));
    rtc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign uv_sum   = nu_reg + nv_reg;
    assign in_range = ($unsigned(det_reg) >= DET_MIN) && !nu_reg[ACC_W-1]
                      && (nu_reg <= det_reg) && !nv_reg[ACC_W-1]
                      && (uv_sum <= det_reg) && !nt_reg[ACC_W-1];
    assign out_free = !m_valid_reg || m_ready;
    assign job_pop  = (state_reg == S_OUT) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (job_valid) state_next = S_GO;
            S_GO:    state_next = S_WAIT;
            S_WAIT: begin
                if (mrsp.done) begin
                    if (step_reg == STEP_W'(LAST_GEOM_STEP)) begin
                        state_next = S_NEG;
                    end else if (step_reg == STEP_W'(LAST_STEP)) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_GO;
                    end
                end
            end
            S_NEG:   state_next = S_EVAL;
            S_EVAL:  state_next = in_range ? S_DIVT : S_OUT;
            S_DIVT:  if (drsp.done) state_next = S_CHECK;
            S_CHECK: state_next = (tq_reg != '0 && tq_reg < closest_reg) ? S_DIVU : S_OUT;
            S_DIVU:  if (drsp.done) state_next = S_DIVV;
            S_DIVV:  if (drsp.done) state_next = S_GO;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_WAIT && mrsp.done) begin
            acc_reg <= acc_sum;
            if (op.last) begin
                case (op.dst)
                    D_P:     p_reg[op.dst_idx] <= PW'(acc_sum);
                    D_DET:   det_reg <= acc_sum;
                    D_NU:    nu_reg <= acc_sum;
                    D_Q:     q_reg[op.dst_idx] <= QW'(acc_sum);
                    D_NV:    nv_reg <= acc_sum;
                    D_NT:    nt_reg <= acc_sum;
                    D_H:     h_reg[op.dst_idx] <= HW'(acc_sum);
                    default: begin
                    end
                endcase
            end
        end
        if (state_reg == S_NEG && det_reg[ACC_W-1]) begin
            det_reg <= -det_reg;
            nu_reg  <= -nu_reg;
            nv_reg  <= -nv_reg;
            nt_reg  <= -nt_reg;
        end
        if (state_reg == S_DIVT && drsp.done) begin
            tq_reg <= drsp.quo[QT_W-1] ? '1 : drsp.quo[TW-1:0];
        end
        if (state_reg == S_DIVU && drsp.done) begin
            u_reg <= drsp.quo[BW-1:0];
        end
        if (state_reg == S_DIVV && drsp.done) begin
            v_reg <= drsp.quo[BW-1:0];
        end
        if (job_pop) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        out_next = '0;
        if (hit_reg) begin
            out_next.nearer_hit = 1'b1;
            out_next.hit_t      = tq_reg;
            out_next.bary_u     = u_reg;
            out_next.bary_v     = v_reg;
            out_next.hit_x      = sat_pos(origin[0], h_reg[0]);
            out_next.hit_y      = sat_pos(origin[1], h_reg[1]);
            out_next.hit_z      = sat_pos(origin[2], h_reg[2]);
        end
        out_next.closest_so_far = closest_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            go_reg      <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            closest_reg <= '1;
        end else begin
            state_reg <= state_next;
            go_reg    <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        step_reg <= '0;
                        if (job.restart) begin
                            closest_reg <= far_limit;
                        end
                    end
                end
                S_WAIT: begin
                    if (mrsp.done) begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_EVAL: begin
                    hit_reg <= 1'b0;
                    go_reg  <= in_range;
                end
                S_CHECK: begin
                    if (tq_reg != '0 && tq_reg < closest_reg) begin
                        closest_reg <= tq_reg;
                        hit_reg     <= 1'b1;
                        go_reg      <= 1'b1;
                    end
                end
                S_DIVU: begin
                    go_reg <= drsp.done;
                end
                S_DIVV: begin
                    if (drsp.done) begin
                        step_reg <= STEP_W'(HIT_STEP);
                    end
                end
                default: begin
                end
            endcase
            if (job_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_pop_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> job_valid)
        else $error("queue popped while empty");

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mreq.start && dreq.start))
        else $error("multiplier and divider started together");

    a_closest_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |=> (closest_reg <= $past(closest_reg)))
        else $error("closest distance grew on a hit test");

    a_hit_is_closest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.nearer_hit) |-> (m_data.hit_t == m_data.closest_so_far))
        else $error("reported hit does not match kept distance");

endmodule

>>> test/ray_triangle_closest_hit_test.sv
`timescale 1ns / 1ps
module ray_triangle_closest_hit_test;
    import rtc_pkg::*;

    localparam int  FRAC      = 16;
    localparam int  LIMIT     = 2500000;
    localparam int  DRAIN     = 1200;
    localparam int  PER_PHASE = 80;

    typedef logic signed [159:0] wide_t;

    class hit_scoreboard;
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic [30:0]        far_limit;
        logic [30:0]        nearest;
        hit_out_t           pending [$];
        int                 errors;

        function new();
            org = '{0, 0, 0};
            dir = '{0, 0, 32'sd65536};
            far_limit = 31'h7FFFFFFF;
            nearest = 31'h7FFFFFFF;
            errors = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                R_ORIGIN_X:  org[0] = val;
                R_ORIGIN_Y:  org[1] = val;
                R_ORIGIN_Z:  org[2] = val;
                R_DIR_X:     dir[0] = val;
                R_DIR_Y:     dir[1] = val;
                R_DIR_Z:     dir[2] = val;
                R_FAR_LIMIT: far_limit = val[30:0];
                default: ;
            endcase
        endfunction

        function automatic logic signed [31:0] sat32(logic signed [95:0] x);
            if (x > 96'sd2147483647) return 32'sh7FFFFFFF;
            if (x < -96'sd2147483648) return 32'sh80000000;
            return x[31:0];
        endfunction

        function void note_triangle(tri_in_t tr);
            wide_t v0 [3], e1 [3], e2 [3], d [3], s [3], p [3], q [3];
            wide_t det, nu, nv, nt, qt, thr;
            logic signed [63:0] tq, prod;
            logic signed [95:0] pos;
            hit_out_t r;
            if (tr.restart) nearest = far_limit;
            v0[0] = tr.v0_x; v0[1] = tr.v0_y; v0[2] = tr.v0_z;
            e1[0] = wide_t'(tr.v1_x) - v0[0];
            e1[1] = wide_t'(tr.v1_y) - v0[1];
            e1[2] = wide_t'(tr.v1_z) - v0[2];
            e2[0] = wide_t'(tr.v2_x) - v0[0];
            e2[1] = wide_t'(tr.v2_y) - v0[1];
            e2[2] = wide_t'(tr.v2_z) - v0[2];
            for (int i = 0; i < 3; i++) begin
                d[i] = dir[i];
                s[i] = wide_t'(org[i]) - v0[i];
            end
            p[0] = d[1] * e2[2] - d[2] * e2[1];
            p[1] = d[2] * e2[0] - d[0] * e2[2];
            p[2] = d[0] * e2[1] - d[1] * e2[0];
            q[0] = s[1] * e1[2] - s[2] * e1[1];
            q[1] = s[2] * e1[0] - s[0] * e1[2];
            q[2] = s[0] * e1[1] - s[1] * e1[0];
            det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
            nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
            nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
            nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
            if (det < 0) begin
                det = -det; nu = -nu; nv = -nv; nt = -nt;
            end
            thr = wide_t'(1) <<< (3 * FRAC);
            r = '0;
            if (!(wide_t'(10000) * det < thr) && nu >= 0 && nu <= det && nv >= 0
                && nu + nv <= det && nt >= 0) begin
                qt = (nt <<< FRAC) / det;
                tq = (qt > wide_t'(32'h7FFFFFFF)) ? 64'sh7FFFFFFF : qt[63:0];
                if (tq > 0 && tq < $signed({33'd0, nearest})) begin
                    nearest = tq[30:0];
                    r.nearer_hit = 1'b1;
                    r.hit_t = tq[30:0];
                    qt = (nu <<< FRAC) / det;
                    r.bary_u = qt[BW-1:0];
                    qt = (nv <<< FRAC) / det;
                    r.bary_v = qt[BW-1:0];
                    prod = 64'(dir[0]) * tq;
                    pos = 96'(org[0]) + 96'(prod >>> FRAC);
                    r.hit_x = sat32(pos);
                    prod = 64'(dir[1]) * tq;
                    pos = 96'(org[1]) + 96'(prod >>> FRAC);
                    r.hit_y = sat32(pos);
                    prod = 64'(dir[2]) * tq;
                    pos = 96'(org[2]) + 96'(prod >>> FRAC);
                    r.hit_z = sat32(pos);
                end
            end
            r.closest_so_far = nearest;
            pending.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s expected %h, got %h", $time, name, e, a);
            end
        endfunction

        function void check_result(hit_out_t a);
            hit_out_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, got %h", $time, a);
                return;
            end
            e = pending.pop_front();
            compare("nearer_hit", e.nearer_hit, a.nearer_hit);
            compare("hit_t", e.hit_t, a.hit_t);
            compare("bary_u", e.bary_u, a.bary_u);
            compare("bary_v", e.bary_v, a.bary_v);
            compare("hit_x", e.hit_x, a.hit_x);
            compare("hit_y", e.hit_y, a.hit_y);
            compare("hit_z", e.hit_z, a.hit_z);
            compare("closest_so_far", e.closest_so_far, a.closest_so_far);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tri_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hit_out_t    m_data;

    hit_scoreboard sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    ray_triangle_closest_hit DUT (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** ray_triangle_closest_hit: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_triangle(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(4 * int'(idx)); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic send_triangle(tri_in_t tr);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= tr;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h0;
            3: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] q16(int whole);
        return 32'(whole) << FRAC;
    endfunction

    function automatic tri_in_t mk_tri(logic rs, logic [31:0] a0, a1, a2, b0, b1, b2,
                                       c0, c1, c2);
        tri_in_t t;
        t.restart = rs;
        t.v0_x = a0; t.v0_y = a1; t.v0_z = a2;
        t.v1_x = b0; t.v1_y = b1; t.v1_z = b2;
        t.v2_x = c0; t.v2_y = c1; t.v2_z = c2;
        return t;
    endfunction

    // triangle around a point on the ray, distance and spread random, at times made degenerate or scrambled
    function automatic tri_in_t ray_tri();
        logic signed [31:0] h [3], a [3], b [3], v0 [3];
        logic signed [63:0] k;
        tri_in_t t;
        k = $urandom_range(32'h00C80000, 1);
        for (int i = 0; i < 3; i++) begin
            h[i] = sb.org[i] + 32'((64'(sb.dir[i]) * k) >>> FRAC);
            a[i] = $signed($urandom_range(32'h00640000)) - 32'sh00320000;
            b[i] = $signed($urandom_range(32'h00640000)) - 32'sh00320000;
            v0[i] = h[i] - (a[i] >>> $urandom_range(3, 1)) - (b[i] >>> $urandom_range(3, 1));
        end
        t = mk_tri($urandom_range(9) == 0, v0[0], v0[1], v0[2],
                   v0[0] + a[0], v0[1] + a[1], v0[2] + a[2],
                   v0[0] + b[0], v0[1] + b[1], v0[2] + b[2]);
        case ($urandom_range(9))
            0: begin t.v2_x = t.v1_x; t.v2_y = t.v1_y; t.v2_z = t.v1_z; end
            1: t.v1_x = any_word();
            2: t.v0_z = t.v0_z + 32'($urandom_range(255));
            3: t = mk_tri(t.restart, any_word(), any_word(), any_word(), any_word(),
                          any_word(), any_word(), any_word(), any_word(), any_word());
            default: ;
        endcase
        return t;
    endfunction

    task automatic run_directed;
        send_triangle(mk_tri(1, q16(-1), q16(-1), q16(5), q16(2), q16(-1), q16(5),
                             q16(-1), q16(2), q16(5)));
        send_triangle(mk_tri(0, q16(-1), q16(-1), q16(8), q16(2), q16(-1), q16(8),
                             q16(-1), q16(2), q16(8)));
        send_triangle(mk_tri(0, q16(-1), q16(-1), q16(3), q16(2), q16(-1), q16(3),
                             q16(-1), q16(2), q16(3)));
        // behind the origin, at the origin
        send_triangle(mk_tri(0, q16(-1), q16(-1), q16(-3), q16(2), q16(-1), q16(-3),
                             q16(-1), q16(2), q16(-3)));
        send_triangle(mk_tri(1, q16(-1), q16(-1), 0, q16(2), q16(-1), 0,
                             q16(-1), q16(2), 0));
        // degenerate and near-zero determinant
        send_triangle(mk_tri(1, 0, 0, q16(2), q16(1), 0, q16(2), q16(1), 0, q16(2)));
        send_triangle(mk_tri(0, 0, 0, q16(2), 32'd1, 0, q16(2), 0, 32'd1, q16(2)));
        // u and v out of range
        send_triangle(mk_tri(0, q16(1), 0, q16(2), q16(3), 0, q16(2), q16(1), q16(2),
                             q16(2)));
        send_triangle(mk_tri(0, 0, q16(1), q16(2), q16(2), q16(1), q16(2), 0, q16(3),
                             q16(2)));
        // reversed winding, then on the edge
        send_triangle(mk_tri(0, q16(-1), q16(-1), q16(2), q16(-1), q16(2), q16(2),
                             q16(2), q16(-1), q16(2)));
        send_triangle(mk_tri(1, 0, q16(-1), q16(1), q16(2), q16(-1), q16(1), 0, q16(2),
                             q16(1)));
        send_triangle(mk_tri(1, q16(-1), q16(-1), 32'd1, q16(2), q16(-1), 32'd1,
                             q16(-1), q16(2), 32'd1));
        send_triangle(mk_tri(1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_triangle(mk_tri(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                             32'h7FFFFFFF));
        send_triangle(mk_tri(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                             32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                             32'h80000000));
        send_triangle(mk_tri(0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                             32'h7FFFFFFF));
        send_triangle(mk_tri(0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                             32'h0));
    endtask

    task automatic configure(int setting);
        case (setting)
            1: begin
                for (int i = 0; i < 3; i++) begin
                    write_reg(reg_idx_t'(i), $signed($urandom_range(32'h01000000))
                              - 32'sh00800000);
                    write_reg(reg_idx_t'(i + 3), $signed($urandom_range(32'h00080000))
                              - 32'sh00040000);
                end
                write_reg(R_FAR_LIMIT, $urandom_range(32'h00C80000, 32'h00010000));
            end
            2: begin
                write_reg(R_ORIGIN_X, 32'h7FFFFFFF);
                write_reg(R_ORIGIN_Y, 32'h80000000);
                write_reg(R_ORIGIN_Z, 32'h0);
                write_reg(R_DIR_X, 32'h7FFFFFFF);
                write_reg(R_DIR_Y, 32'h80000000);
                write_reg(R_DIR_Z, 32'h00010000);
                write_reg(R_FAR_LIMIT, 32'h7FFFFFFF);
            end
            3: begin
                write_reg(R_ORIGIN_X, 32'h0);
                write_reg(R_ORIGIN_Y, 32'h0);
                write_reg(R_ORIGIN_Z, 32'hFFF00000);
                write_reg(R_DIR_X, 32'h0);
                write_reg(R_DIR_Y, 32'h00008000);
                write_reg(R_DIR_Z, 32'h00020000);
                write_reg(R_FAR_LIMIT, 32'h0);
            end
            default: begin
                for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), any_word());
                write_reg(R_FAR_LIMIT, any_word());
            end
        endcase
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) configure(ph);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == 1 && n == PER_PHASE / 2) begin
                    s_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge aclk);
                end
                if ($urandom_range(99) < 75) send_triangle(ray_tri());
                else send_triangle(mk_tri($urandom_range(1), any_word(), any_word(),
                                          any_word(), any_word(), any_word(), any_word(),
                                          any_word(), any_word(), any_word()));
            end
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** ray_triangle_closest_hit: PASSED **");
        else
            $display("** ray_triangle_closest_hit: FAILED **");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/rtc_pkg.sv
rtl/core/rtc_front.sv
rtl/core/rtc_mul.sv
rtl/core/rtc_div.sv
rtl/core/rtc_back.sv
rtl/core/ray_triangle_closest_hit.sv
test/ray_triangle_closest_hit_test.sv
